// ===== hdl/delta_minmax_normalizer_top_macros.svh =====
// ----------------------------------------------------------------------------
// delta_minmax_normalizer_top_macros
// assertion macros shared by the normalizer modules
// ----------------------------------------------------------------------------
`ifndef DELTA_MINMAX_NORMALIZER_TOP_MACROS_SVH
`define DELTA_MINMAX_NORMALIZER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define DMN_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DMN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define DMN_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define DMN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/dmn_pkg.sv =====
// ----------------------------------------------------------------------------
// dmn_pkg
// shared constants, codes and types of the delta min-max normalizer
// ----------------------------------------------------------------------------
package dmn_pkg;

   // storage geometry
   localparam int MAX_STEPS    = 1024;
   localparam int MAX_FEATURES = 8;
   localparam int STORE_DEPTH  = MAX_STEPS * MAX_FEATURES;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);

   // field widths
   localparam int DATA_W  = 32;
   localparam int MODE_W  = 2;
   localparam int STEP_W  = 10;
   localparam int FEAT_W  = 3;
   localparam int FCNT_W  = 4;
   localparam int CSR_IDX_W = 2;

   // stream packing
   localparam int STEP_LSB    = 0;
   localparam int FEAT_LSB    = STEP_LSB + STEP_W;
   localparam int SAMPLE_LSB  = FEAT_LSB + FEAT_W;
   localparam int REQ_FIELDS_W = SAMPLE_LSB + DATA_W;
   localparam int REQ_TDATA_W = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = DATA_W;

   // divider: quotient bits below the saturation point
   localparam int PROD_W    = 2 * DATA_W;
   localparam int DIV_BITS  = DATA_W + 1;
   localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);

   // signed limits
   localparam logic [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FEATURE_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSFORM_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_MIN      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_MAX      = 2'd3;

   // register reset values
   localparam logic [FCNT_W-1:0] FEATURE_COUNT_RST  = 4'd5;
   localparam logic              TRANSFORM_MODE_RST = 1'b1;
   localparam logic [DATA_W-1:0] SCALE_MIN_RST      = 32'hFFFF_0000;
   localparam logic [DATA_W-1:0] SCALE_MAX_RST      = 32'h0001_0000;

   // item kinds
   typedef enum logic [MODE_W-1:0] {
      MODE_BASE   = 2'd0,
      MODE_SAMPLE = 2'd1,
      MODE_READ   = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PREP,
      ST_MUL,
      ST_CHK,
      ST_DIV,
      ST_FIN,
      ST_OUT
   } state_type;

   // configuration registers
   typedef struct packed {
      logic [FCNT_W-1:0] feature_count;
      logic              transform_mode;
      logic [DATA_W-1:0] scale_min;
      logic [DATA_W-1:0] scale_max;
   } cfg_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic exec;
      logic prep;
      logic mul;
      logic chk;
      logic div;
      logic fin;
      logic out_load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      mode_type mode;
      logic     read_ok;
      logic     sat;
      logic     div_done;
      logic     out_free;
   } status_type;

endpackage

// ===== hdl/dmn_csr.sv =====
// ----------------------------------------------------------------------------
// dmn_csr
// configuration register file, write only
// ----------------------------------------------------------------------------
module dmn_csr
   import dmn_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_FEATURE_COUNT:  cfg_in.feature_count  = csr_wdata[FCNT_W-1:0];
            CSR_TRANSFORM_MODE: cfg_in.transform_mode = csr_wdata[0];
            CSR_SCALE_MIN:      cfg_in.scale_min      = csr_wdata;
            CSR_SCALE_MAX:      cfg_in.scale_max      = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // register state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.feature_count  <= FEATURE_COUNT_RST;
         cfg_ff.transform_mode <= TRANSFORM_MODE_RST;
         cfg_ff.scale_min      <= SCALE_MIN_RST;
         cfg_ff.scale_max      <= SCALE_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/dmn_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmn_ctrl
// sequencer for item decode, scaling multiply and iterative divide
// ----------------------------------------------------------------------------
`include "delta_minmax_normalizer_top_macros.svh"

module dmn_ctrl
   import dmn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.mode == MODE_READ) begin
               state_in = status.read_ok ? ST_PREP : ST_OUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PREP: state_in = ST_MUL;
         ST_MUL:  state_in = ST_CHK;
         ST_CHK: begin
            state_in = status.sat ? ST_FIN : ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_FIN;
         end
         ST_FIN: state_in = ST_OUT;
         ST_OUT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_EXEC: cmd.exec = 1'b1;
         ST_PREP: cmd.prep = 1'b1;
         ST_MUL:  cmd.mul  = 1'b1;
         ST_CHK:  cmd.chk  = 1'b1;
         ST_DIV:  cmd.div  = 1'b1;
         ST_FIN:  cmd.fin  = 1'b1;
         ST_OUT:  cmd.out_load = status.out_free;
         default: cmd = '0;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   `DMN_ASSERT_SAME(a_out_load_free, clock, reset, cmd.out_load, status.out_free, "result loaded over a pending transfer")
   `DMN_ASSERT_NEXT(a_accept_exec, clock, reset, req_tvalid && req_tready, state_ff == ST_EXEC, "accepted item not decoded")
   `DMN_ASSERT_NEXT(a_div_to_fin, clock, reset, (state_ff == ST_DIV) && status.div_done, state_ff == ST_FIN, "divide did not finish")

endmodule

// ===== hdl/dmn_datapath.sv =====
// ----------------------------------------------------------------------------
// dmn_datapath
// feature state, sample store, scaling multiplier, divider and result register
// ----------------------------------------------------------------------------
`include "delta_minmax_normalizer_top_macros.svh"

module dmn_datapath
   import dmn_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [MODE_W-1:0]      req_tuser,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser
);

   // item registers
   mode_type            mode_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [FEAT_W-1:0]   feat_ff;
   logic [DATA_W-1:0]   sample_ff;

   // per-feature state
   logic [DATA_W-1:0]   prev_ff [MAX_FEATURES];
   logic [DATA_W-1:0]   min_ff  [MAX_FEATURES];
   logic [DATA_W-1:0]   max_ff  [MAX_FEATURES];

   // sample store
   logic [DATA_W-1:0]   store_mem [STORE_DEPTH];
   logic [DATA_W-1:0]   mem_rd_ff;

   // scaling operands and divider
   logic [DATA_W-1:0]   a_ff;
   logic [DATA_W-1:0]   b_ff;
   logic [DATA_W-1:0]   den_ff;
   logic                neg_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                sat_ff;
   logic [DATA_W-1:0]   rem_ff;
   logic [DIV_BITS-1:0] dvd_ff;
   logic [DIV_BITS-1:0] q_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;

   // result and output registers
   logic [DATA_W-1:0]   res_val_ff;
   logic                res_err_ff;
   logic                rsp_tvalid_ff;
   logic [DATA_W-1:0]   rsp_data_ff;
   logic                rsp_err_ff;

   // decode signals
   logic [FCNT_W-1:0]   fc_eff;
   logic                fok;
   logic                sok;
   logic [ADDR_W-1:0]   addr;
   logic [DATA_W-1:0]   prev_sel;
   logic [DATA_W-1:0]   lo_sel;
   logic [DATA_W-1:0]   hi_sel;
   logic [DATA_W:0]     diff;
   logic [DATA_W-1:0]   diff_sat;
   logic [DATA_W-1:0]   trans;
   logic                base_ok;
   logic                write_ok;
   logic                read_ok;
   logic                trans_lt_lo;
   logic                trans_gt_hi;

   // operand preparation
   logic [DATA_W:0]     off;
   logic [DATA_W:0]     span;
   logic [DATA_W:0]     off_mag;
   logic [DATA_W:0]     span_mag;
   logic [DATA_W:0]     den_full;

   // divider step and final sum
   logic                sat_now;
   logic [DATA_W:0]     trial;
   logic                qb;
   logic [DATA_W:0]     trial_sub;
   logic [DATA_W+2:0]   q_ext;
   logic [DATA_W+2:0]   sum;
   logic [DATA_W-1:0]   scaled;

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= mode_type'(req_tuser);
         step_ff   <= req_tdata[STEP_LSB +: STEP_W];
         feat_ff   <= req_tdata[FEAT_LSB +: FEAT_W];
         sample_ff <= req_tdata[SAMPLE_LSB +: DATA_W];
      end
   end

   // item decode and sample transform
   always_comb begin
      fc_eff   = (cfg.feature_count > FCNT_W'(MAX_FEATURES)) ?
                 FCNT_W'(MAX_FEATURES) : cfg.feature_count;
      fok      = {1'b0, feat_ff} < fc_eff;
      sok      = int'(step_ff) < MAX_STEPS;
      addr     = ADDR_W'(int'(step_ff) * MAX_FEATURES + int'(feat_ff));
      prev_sel = prev_ff[feat_ff];
      lo_sel   = min_ff[feat_ff];
      hi_sel   = max_ff[feat_ff];
      diff     = {sample_ff[DATA_W-1], sample_ff} - {prev_sel[DATA_W-1], prev_sel};
      if (diff[DATA_W] != diff[DATA_W-1]) begin
         diff_sat = diff[DATA_W] ? INT_MIN : INT_MAX;
      end else begin
         diff_sat = diff[DATA_W-1:0];
      end
      trans       = cfg.transform_mode ? diff_sat : sample_ff;
      trans_lt_lo = $signed(trans) < $signed(lo_sel);
      trans_gt_hi = $signed(trans) > $signed(hi_sel);
      base_ok     = cmd.exec && (mode_ff == MODE_BASE) && fok;
      write_ok    = cmd.exec && (mode_ff == MODE_SAMPLE) && fok && sok;
      read_ok     = fok && sok && ($signed(hi_sel) > $signed(lo_sel));
   end

   // per-feature previous value, min and max
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int f = 0; f < MAX_FEATURES; f++) begin
            prev_ff[f] <= '0;
            min_ff[f]  <= INT_MAX;
            max_ff[f]  <= INT_MIN;
         end
      end else begin
         if (base_ok) prev_ff[feat_ff] <= sample_ff;
         if (write_ok) begin
            prev_ff[feat_ff] <= sample_ff;
            if (trans_lt_lo) min_ff[feat_ff] <= trans;
            if (trans_gt_hi) max_ff[feat_ff] <= trans;
         end
      end
   end

   // sample store, registered read
   always_ff @(posedge clock) begin
      if (write_ok) store_mem[addr] <= trans;
      mem_rd_ff <= store_mem[addr];
   end

   // offset from max, target span and source range
   always_comb begin
      off      = {mem_rd_ff[DATA_W-1], mem_rd_ff} - {hi_sel[DATA_W-1], hi_sel};
      span     = {cfg.scale_max[DATA_W-1], cfg.scale_max}
               - {cfg.scale_min[DATA_W-1], cfg.scale_min};
      off_mag  = off[DATA_W] ? ((DATA_W+1)'(0) - off) : off;
      span_mag = span[DATA_W] ? ((DATA_W+1)'(0) - span) : span;
      den_full = {hi_sel[DATA_W-1], hi_sel} - {lo_sel[DATA_W-1], lo_sel};
   end

   // divider step: quotient saturates when the high product bits reach the divisor
   always_comb begin
      sat_now   = {1'b0, prod_ff[PROD_W-1:DIV_BITS]} >= den_ff;
      trial     = {rem_ff, dvd_ff[DIV_BITS-1]};
      qb        = trial >= {1'b0, den_ff};
      trial_sub = trial - {1'b0, den_ff};
   end

   // final sum with signed saturation
   always_comb begin
      q_ext = {2'b00, q_ff};
      sum   = {{3{cfg.scale_max[DATA_W-1]}}, cfg.scale_max}
            + (neg_ff ? ((DATA_W+3)'(0) - q_ext) : q_ext);
      if (sat_ff) begin
         scaled = neg_ff ? INT_MIN : INT_MAX;
      end else if (sum[DATA_W+2:DATA_W-1] != {4{sum[DATA_W+2]}}) begin
         scaled = sum[DATA_W+2] ? INT_MIN : INT_MAX;
      end else begin
         scaled = sum[DATA_W-1:0];
      end
   end

   // multiply and divide registers
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         a_ff   <= off_mag[DATA_W-1:0];
         b_ff   <= span_mag[DATA_W-1:0];
         den_ff <= den_full[DATA_W-1:0];
         neg_ff <= off[DATA_W] ^ span[DATA_W];
      end
      if (cmd.mul) begin
         prod_ff <= a_ff * b_ff;
      end
      if (cmd.chk) begin
         sat_ff <= sat_now;
         rem_ff <= {1'b0, prod_ff[PROD_W-1:DIV_BITS]};
         dvd_ff <= prod_ff[DIV_BITS-1:0];
         q_ff   <= '0;
         cnt_ff <= DIV_CNT_W'(DIV_BITS);
      end
      if (cmd.div) begin
         rem_ff <= qb ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
         dvd_ff <= {dvd_ff[DIV_BITS-2:0], 1'b0};
         q_ff   <= {q_ff[DIV_BITS-2:0], qb};
         cnt_ff <= cnt_ff - DIV_CNT_W'(1);
      end
   end

   // pending result
   always_ff @(posedge clock) begin
      if (cmd.exec && (mode_ff == MODE_READ)) begin
         res_val_ff <= '0;
         res_err_ff <= !read_ok;
      end
      if (cmd.fin) begin
         res_val_ff <= scaled;
         res_err_ff <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= res_val_ff;
         rsp_err_ff  <= res_err_ff;
      end
   end

   // status to controller
   always_comb begin
      status.mode     = mode_ff;
      status.read_ok  = read_ok;
      status.sat      = sat_now;
      status.div_done = cnt_ff == DIV_CNT_W'(1);
      status.out_free = !rsp_tvalid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

   // checks
   `DMN_ASSERT_SAME(a_rem_below_den, clock, reset, cmd.div, rem_ff < den_ff, "divider remainder not below divisor")
   `DMN_ASSERT_NEXT(a_out_valid, clock, reset, cmd.out_load, rsp_tvalid_ff, "loaded result not presented")
   `DMN_ASSERT_NEXT(a_sat_pos, clock, reset, cmd.fin && sat_ff && !neg_ff, res_val_ff == INT_MAX, "saturated quotient not clipped high")

endmodule

// ===== hdl/delta_minmax_normalizer_top.sv =====
// ----------------------------------------------------------------------------
// delta_minmax_normalizer_top
// min-max normalizer of a differenced multi-feature series
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one item per transfer. req_tuser holds the item kind
//   (base value, sample, read). Base items set the per-feature previous value;
//   sample items also update min, max and the 8K-entry sample store. Neither
//   gives a result. A read returns one transfer on rsp: the stored value scaled
//   into [scale_min, scale_max], with rsp_tuser set and data 0 when the feature
//   range is empty or flat or the step or feature is out of range.
//   Base and sample items go from decode back to idle. A scaled read runs
//   decode, store read, 32x32 multiply, a saturation check and a 33-step
//   restoring divider at one quotient bit per cycle; the divider sets the
//   rate, and a saturated quotient skips it. Rejected reads go to output.
//   The result sits in an output register; a new item is taken while it
//   waits, and a later read holds in its last stage until rsp_tready frees
//   the register.
//   Reset clears the controller and output valid and loads the configuration
//   and per-feature state reset values; the sample store is not cleared and
//   a step must be written before it is read. The user writes configuration by
//   csr_wen, csr_index, csr_wdata while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module delta_minmax_normalizer_top
   import dmn_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // step_index, feature_index, sample_value
   input  logic [MODE_W-1:0]      req_tuser,  // mode
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // scaled_value
   output logic                   rsp_tuser,  // range_error
   // configuration writes
   input  logic                   csr_wen,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [DATA_W-1:0]      csr_wdata
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // configuration registers
   dmn_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer
   dmn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // state, store and arithmetic
   dmn_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
